// ===== rtl/cpslm_pkg.sv =====
package cpslm_pkg;

   localparam int CP_W     = 21;
   localparam int SPR_W    = 16;
   localparam int LEN_W    = 5;
   localparam int IDX_W    = 12;
   localparam int TOFF_W   = 12;
   localparam int CNT_W    = 17;
   localparam int SCNT_W   = 12;
   localparam int QCNT_W   = 11;
   localparam int CSR_W    = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] OP_LOAD_SINGLE = 2'd0;
   localparam logic [1:0] OP_LOAD_SEQ    = 2'd1;
   localparam logic [1:0] OP_LOAD_TAIL   = 2'd2;
   localparam logic [1:0] OP_QUERY       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SGL_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_LIMIT = 2'd1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [IDX_W-1:0]  index;
      logic [CP_W-1:0]   codepoint;
      logic [SPR_W-1:0]  sprite_id;
      logic [LEN_W-1:0]  seq_length;
      logic [TOFF_W-1:0] tail_offset;
      logic              last;
   } req_data_type;

   typedef struct packed {
      logic [LEN_W-1:0] match_length;
      logic [SPR_W-1:0] match_sprite;
   } rsp_data_type;

   typedef struct packed {
      logic [CP_W-1:0]  cp;
      logic [SPR_W-1:0] spr;
   } single_entry_type;

   typedef struct packed {
      logic [CP_W-1:0]   lead;
      logic [SPR_W-1:0]  spr;
      logic [LEN_W-1:0]  len;
      logic [TOFF_W-1:0] toff;
   } seq_entry_type;

   typedef struct packed {
      logic         valid;
      req_data_type item;
   } queue_out_type;

endpackage

// ===== rtl/cpslm_ram.sv =====
module cpslm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cpslm_front.sv =====
module cpslm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  cpslm_pkg::req_data_type req_data,
   output logic                    busy,
   input  logic                    pop,
   output cpslm_pkg::queue_out_type q_out
);

   cpslm_pkg::req_data_type slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       wr_ptr;

   assign busy   = (count_ff == 2'd2);
   assign push   = start && !busy;
   assign wr_ptr = rd_ptr_ff ^ count_ff[0];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (pop && count_ff != 2'd0) begin
         rd_ptr_in = !rd_ptr_ff;
         count_in  = count_in - 2'd1;
      end
      if (push) begin
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr] <= req_data;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      busy && !pop |=> count_ff == 2'd2) else $error("queue lost an entry");

endmodule

// ===== rtl/cpslm_back.sv =====
module cpslm_back #(
   parameter int SINGLE_DEPTH   = 2048,
   parameter int SEQUENCE_DEPTH = 1024,
   parameter int TAIL_DEPTH     = 4096,
   parameter int MAX_WINDOW     = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cpslm_pkg::queue_out_type q_out,
   output logic                     pop,
   input  logic [cpslm_pkg::SCNT_W-1:0] sgl_limit,
   input  logic [cpslm_pkg::QCNT_W-1:0] seq_limit,
   output logic                     rsp_valid,
   output cpslm_pkg::rsp_data_type  rsp_data
);

   localparam int SAW = SINGLE_DEPTH > 1 ? $clog2(SINGLE_DEPTH) : 1;
   localparam int QAW = SEQUENCE_DEPTH > 1 ? $clog2(SEQUENCE_DEPTH) : 1;
   localparam int TAW = TAIL_DEPTH > 1 ? $clog2(TAIL_DEPTH) : 1;
   localparam int TAD_W = (TAW > cpslm_pkg::TOFF_W ? TAW : cpslm_pkg::TOFF_W) + 1;
   localparam int WW = $clog2(MAX_WINDOW);
   localparam int FW = $clog2(MAX_WINDOW + 1);
   localparam int CW = cpslm_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_RD, ST_SQ_CMP, ST_SC_RD, ST_SC_CHK, ST_TL_MOD, ST_TL_CHK,
      ST_SG_RD, ST_SG_CMP, ST_SG_FIN, ST_SG_CHK
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [FW-1:0] fill_ff, fill_in, cnt_ff, cnt_in;
   logic [cpslm_pkg::CP_W-1:0] lead_ff, lead_in;
   logic [cpslm_pkg::LEN_W-1:0] elen_ff, elen_in, k_ff, k_in;
   logic [cpslm_pkg::SPR_W-1:0] espr_ff, espr_in;
   logic [TAD_W-1:0] taddr_ff, taddr_in;
   logic [cpslm_pkg::CP_W-1:0] window_ff [MAX_WINDOW];
   logic rsp_valid_ff, rsp_valid_in;
   cpslm_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0] nsgl, nseq;
   logic win_we;

   logic sgl_we, seq_we, tail_we;
   logic [SAW-1:0] sgl_raddr;
   logic [QAW-1:0] seq_raddr;
   logic [TAW-1:0] tail_raddr;
   cpslm_pkg::single_entry_type sgl_wdata, sgl_rdata;
   cpslm_pkg::seq_entry_type seq_wdata, seq_rdata;
   logic [cpslm_pkg::CP_W-1:0] tail_rdata;
   cpslm_pkg::req_data_type it;

   assign it  = q_out.item;
   assign pop = (state_ff == ST_IDLE);
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign nsgl = (CW'(sgl_limit) > CW'(SINGLE_DEPTH)) ? CW'(SINGLE_DEPTH)
                                                      : CW'(sgl_limit);
   assign nseq = (CW'(seq_limit) > CW'(SEQUENCE_DEPTH)) ? CW'(SEQUENCE_DEPTH)
                                                        : CW'(seq_limit);

   assign sgl_wdata.cp  = it.codepoint;
   assign sgl_wdata.spr = it.sprite_id;
   assign seq_wdata.lead = it.codepoint;
   assign seq_wdata.spr  = it.sprite_id;
   assign seq_wdata.len  = it.seq_length;
   assign seq_wdata.toff = it.tail_offset;

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      lead_in      = lead_ff;
      elen_in      = elen_ff;
      espr_in      = espr_ff;
      k_in         = k_ff;
      taddr_in     = taddr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      sgl_we       = 1'b0;
      seq_we       = 1'b0;
      tail_we      = 1'b0;
      win_we       = 1'b0;
      sgl_raddr    = SAW'(lo_ff);
      seq_raddr    = QAW'(lo_ff);
      tail_raddr   = TAW'(taddr_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               unique case (it.req_type)
                  cpslm_pkg::OP_LOAD_SINGLE:
                     sgl_we = (CW'(it.index) < CW'(SINGLE_DEPTH));
                  cpslm_pkg::OP_LOAD_SEQ:
                     seq_we = (CW'(it.index) < CW'(SEQUENCE_DEPTH));
                  cpslm_pkg::OP_LOAD_TAIL:
                     tail_we = (CW'(it.index) < CW'(TAIL_DEPTH));
                  default: begin
                     if (fill_ff < FW'(MAX_WINDOW)) begin
                        win_we  = 1'b1;
                        fill_in = fill_ff + FW'(1);
                     end
                     if (it.last) begin
                        cnt_in   = fill_in;
                        lead_in  = (fill_ff == '0) ? it.codepoint : window_ff[0];
                        fill_in  = '0;
                        lo_in    = '0;
                        hi_in    = nseq;
                        state_in = ST_SQ_RD;
                     end
                  end
               endcase
            end
         end
         ST_SQ_RD: begin
            seq_raddr = QAW'(mid);
            state_in  = (lo_ff < hi_ff) ? ST_SQ_CMP : ST_SC_RD;
         end
         ST_SQ_CMP: begin
            if (seq_rdata.lead < lead_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SQ_RD;
         end
         ST_SC_RD: begin
            if (lo_ff < nseq) begin
               state_in = ST_SC_CHK;
            end else begin
               lo_in    = '0;
               hi_in    = nsgl;
               state_in = ST_SG_RD;
            end
         end
         ST_SC_CHK: begin
            priority if (seq_rdata.lead != lead_ff) begin
               lo_in    = '0;
               hi_in    = nsgl;
               state_in = ST_SG_RD;
            end else if (seq_rdata.len == '0 ||
                         {1'b0, seq_rdata.len} > 6'(cnt_ff)) begin
               lo_in    = lo_ff + CW'(1);
               state_in = ST_SC_RD;
            end else if (seq_rdata.len == cpslm_pkg::LEN_W'(1)) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.match_length = seq_rdata.len;
               rsp_data_in.match_sprite = seq_rdata.spr;
               state_in                 = ST_IDLE;
            end else begin
               elen_in  = seq_rdata.len;
               espr_in  = seq_rdata.spr;
               taddr_in = TAD_W'(seq_rdata.toff);
               k_in     = cpslm_pkg::LEN_W'(1);
               state_in = ST_TL_MOD;
            end
         end
         ST_TL_MOD: begin
            if (taddr_ff >= TAD_W'(TAIL_DEPTH)) begin
               taddr_in = taddr_ff - TAD_W'(TAIL_DEPTH);
            end else begin
               state_in = ST_TL_CHK;
            end
         end
         ST_TL_CHK: begin
            priority if (window_ff[k_ff[WW-1:0]] != tail_rdata) begin
               lo_in    = lo_ff + CW'(1);
               state_in = ST_SC_RD;
            end else if (k_ff + cpslm_pkg::LEN_W'(1) == elen_ff) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.match_length = elen_ff;
               rsp_data_in.match_sprite = espr_ff;
               state_in                 = ST_IDLE;
            end else begin
               k_in     = k_ff + cpslm_pkg::LEN_W'(1);
               taddr_in = taddr_ff + TAD_W'(1);
               state_in = ST_TL_MOD;
            end
         end
         ST_SG_RD: begin
            sgl_raddr = SAW'(mid);
            state_in  = (lo_ff < hi_ff) ? ST_SG_CMP : ST_SG_FIN;
         end
         ST_SG_CMP: begin
            if (sgl_rdata.cp < lead_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SG_RD;
         end
         ST_SG_FIN: begin
            if (lo_ff < nsgl) begin
               state_in = ST_SG_CHK;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_SG_CHK: begin
            rsp_valid_in = 1'b1;
            if (sgl_rdata.cp == lead_ff) begin
               rsp_data_in.match_length = cpslm_pkg::LEN_W'(1);
               rsp_data_in.match_sprite = sgl_rdata.spr;
            end else begin
               rsp_data_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      cnt_ff      <= cnt_in;
      lead_ff     <= lead_in;
      elen_ff     <= elen_in;
      espr_ff     <= espr_in;
      k_ff        <= k_in;
      taddr_ff    <= taddr_in;
      rsp_data_ff <= rsp_data_in;
      if (win_we) begin
         window_ff[fill_ff[WW-1:0]] <= it.codepoint;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cpslm_ram #(.WIDTH($bits(cpslm_pkg::single_entry_type)), .DEPTH(SINGLE_DEPTH)) u_sgl (
      .clock (clock),
      .we    (sgl_we),
      .waddr (SAW'(it.index)),
      .wdata (sgl_wdata),
      .raddr (sgl_raddr),
      .rdata (sgl_rdata)
   );

   cpslm_ram #(.WIDTH($bits(cpslm_pkg::seq_entry_type)), .DEPTH(SEQUENCE_DEPTH)) u_seq (
      .clock (clock),
      .we    (seq_we),
      .waddr (QAW'(it.index)),
      .wdata (seq_wdata),
      .raddr (seq_raddr),
      .rdata (seq_rdata)
   );

   cpslm_ram #(.WIDTH(cpslm_pkg::CP_W), .DEPTH(TAIL_DEPTH)) u_tail (
      .clock (clock),
      .we    (tail_we),
      .waddr (TAW'(it.index)),
      .wdata (it.codepoint),
      .raddr (tail_raddr),
      .rdata (tail_rdata)
   );

   a_rsp_ends_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("result outside query end");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_WINDOW)) else $error("window fill overflow");
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.match_length == '0 |-> rsp_data_ff.match_sprite == '0)
      else $error("sprite set without match");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_CMP || state_ff == ST_SG_CMP) |-> lo_ff < hi_ff)
      else $error("search bounds crossed");

endmodule

// ===== rtl/codepoint_sequence_longest_match_top.sv =====
// channel   | ports                      | handshake
// request   | start, busy, req_data      | taken when start && !busy
// response  | rsp_valid, rsp_data        | one-cycle strobe, no backpressure
// csr       | csr_we, csr_index, csr_wdata | written when csr_we
//
// Loads and non-final query codepoints are handled in the lookup engine's idle state.
// A final codepoint starts a binary search of the sequence table for the window's lead,
// then a scan of the entries with that lead and a compare of their tail words and, if
// none matches, a binary search of the single table; the tables have registered reads.
// A two-entry request queue decouples intake; busy is high while it is full.
// Reset is synchronous and clears control state only; tables are undefined.
module codepoint_sequence_longest_match_top #(
   parameter int SINGLE_DEPTH   = 2048,
   parameter int SEQUENCE_DEPTH = 1024,
   parameter int TAIL_DEPTH     = 4096,
   parameter int MAX_WINDOW     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  cpslm_pkg::req_data_type req_data,
   output logic                    rsp_valid,
   output cpslm_pkg::rsp_data_type rsp_data,
   input  logic                    csr_we,
   input  logic [cpslm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpslm_pkg::CSR_W-1:0]     csr_wdata
);

   logic [cpslm_pkg::SCNT_W-1:0] sgl_limit_ff;
   logic [cpslm_pkg::QCNT_W-1:0] seq_limit_ff;
   logic pop;
   cpslm_pkg::queue_out_type q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         sgl_limit_ff <= '0;
         seq_limit_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == cpslm_pkg::CSR_SGL_LIMIT) begin
            sgl_limit_ff <= csr_wdata;
         end
         if (csr_index == cpslm_pkg::CSR_SEQ_LIMIT) begin
            seq_limit_ff <= csr_wdata[cpslm_pkg::QCNT_W-1:0];
         end
      end
   end

   cpslm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .pop      (pop),
      .q_out    (q_out)
   );

   cpslm_back #(
      .SINGLE_DEPTH   (SINGLE_DEPTH),
      .SEQUENCE_DEPTH (SEQUENCE_DEPTH),
      .TAIL_DEPTH     (TAIL_DEPTH),
      .MAX_WINDOW     (MAX_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .pop       (pop),
      .sgl_limit (sgl_limit_ff),
      .seq_limit (seq_limit_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/codepoint_sequence_longest_match_top_tb.sv =====
`timescale 1ns / 1ps

module codepoint_sequence_longest_match_top_tb;

   localparam int CP_W      = cpslm_pkg::CP_W;
   localparam int LEN_W     = cpslm_pkg::LEN_W;
   localparam int IDX_W     = cpslm_pkg::IDX_W;
   localparam int TOFF_W    = cpslm_pkg::TOFF_W;
   localparam int CSR_W     = cpslm_pkg::CSR_W;
   localparam int CSR_IDX_W = cpslm_pkg::CSR_IDX_W;
   localparam int SCNT_W    = cpslm_pkg::SCNT_W;
   localparam int QCNT_W    = cpslm_pkg::QCNT_W;

   localparam int SGL_DEPTH   = 2048;
   localparam int SEQ_DEPTH   = 1024;
   localparam int TAIL_DEPTH  = 4096;
   localparam int WIN_MAX     = 16;
   localparam int SGL_FILL    = 256;
   localparam int SEQ_FILL    = 256;
   localparam int PHASES      = 6;
   localparam int PHASE_OPS   = 34;
   localparam int DRAIN_WAIT  = 400;
   localparam int QUIET_LIMIT = 6000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cpslm_pkg::req_data_type req_data = '0;
   logic rsp_valid;
   cpslm_pkg::rsp_data_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   codepoint_sequence_longest_match_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state, advanced on accepted requests
   cpslm_pkg::single_entry_type sgl_tab [SGL_DEPTH];
   cpslm_pkg::seq_entry_type seq_tab [SEQ_DEPTH];
   logic [CP_W-1:0] tail_mem [TAIL_DEPTH];
   logic [CP_W-1:0] window [WIN_MAX];
   int window_fill = 0;
   int sgl_limit = 0;
   int seq_limit = 0;

   // shadow tables as they will stand once the backlog is sent
   cpslm_pkg::single_entry_type gen_sgl [SGL_DEPTH];
   cpslm_pkg::seq_entry_type gen_seq [SEQ_DEPTH];
   logic [CP_W-1:0] gen_tail [TAIL_DEPTH];

   cpslm_pkg::req_data_type req_backlog [$];
   cpslm_pkg::rsp_data_type pending_matches [$];
   int error_count = 0;
   int gap_left = 0;
   int burst_pct = 0;
   int quiet_cycles = 0;

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic cpslm_pkg::rsp_data_type lookup_window();
      cpslm_pkg::rsp_data_type r;
      int n, lo, hi, mid, i, k;
      bit ok;
      logic [CP_W-1:0] lead;
      r = '0;
      lead = window[0];
      n = (seq_limit > SEQ_DEPTH) ? SEQ_DEPTH : seq_limit;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (seq_tab[mid].lead < lead) lo = mid + 1;
         else hi = mid;
      end
      for (i = lo; i < n && seq_tab[i].lead == lead; i++) begin
         if (seq_tab[i].len == 0 || seq_tab[i].len > window_fill) continue;
         ok = 1'b1;
         for (k = 1; k < seq_tab[i].len; k++) begin
            if (window[k] != tail_mem[(int'(seq_tab[i].toff) + k - 1) % TAIL_DEPTH]) begin
               ok = 1'b0;
               break;
            end
         end
         if (ok) begin
            r.match_length = seq_tab[i].len;
            r.match_sprite = seq_tab[i].spr;
            return r;
         end
      end
      n = (sgl_limit > SGL_DEPTH) ? SGL_DEPTH : sgl_limit;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (sgl_tab[mid].cp < lead) lo = mid + 1;
         else hi = mid;
      end
      if (lo < n && sgl_tab[lo].cp == lead) begin
         r.match_length = LEN_W'(1);
         r.match_sprite = sgl_tab[lo].spr;
      end
      return r;
   endfunction

   task automatic absorb_request(input cpslm_pkg::req_data_type q);
      case (q.req_type)
         cpslm_pkg::OP_LOAD_SINGLE:
            if (q.index < SGL_DEPTH) sgl_tab[q.index] = '{q.codepoint, q.sprite_id};
         cpslm_pkg::OP_LOAD_SEQ: if (q.index < SEQ_DEPTH)
            seq_tab[q.index] = '{q.codepoint, q.sprite_id, q.seq_length, q.tail_offset};
         cpslm_pkg::OP_LOAD_TAIL: tail_mem[q.index] = q.codepoint;
         default: begin
            if (window_fill < WIN_MAX) begin
               window[window_fill] = q.codepoint;
               window_fill++;
            end
            if (q.last) begin
               pending_matches.push_back(lookup_window());
               window_fill = 0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (!start || !busy) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            start <= 1'b1;
            req_data <= req_backlog.pop_front();
            if ($urandom_range(99) < burst_pct) gap_left = $urandom_range(1, 7);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cpslm_pkg::rsp_data_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_matches.size() == 0) begin
               flag_mismatch("result with none expected");
            end else begin
               want = pending_matches.pop_front();
               if (rsp_data.match_length !== want.match_length)
                  flag_mismatch($sformatf("match_length %0d, want %0d",
                     rsp_data.match_length, want.match_length));
               if (rsp_data.match_sprite !== want.match_sprite)
                  flag_mismatch($sformatf("match_sprite %0h, want %0h",
                     rsp_data.match_sprite, want.match_sprite));
            end
         end
         if (start && !busy) absorb_request(req_data);
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   function automatic cpslm_pkg::req_data_type noise_req();
      logic [95:0] r;
      r = {$urandom(), $urandom(), $urandom()};
      return r[$bits(cpslm_pkg::req_data_type)-1:0];
   endfunction

   function automatic logic [TOFF_W-1:0] pick_toff();
      if ($urandom_range(3) == 0) return TOFF_W'(4080 + $urandom_range(0, 15));
      return TOFF_W'($urandom_range(0, 48));
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(15) == 0) return LEN_W'($urandom_range(17, 31));
      return LEN_W'($urandom_range(0, 16));
   endfunction

   task automatic push_req(input cpslm_pkg::req_data_type q);
      case (q.req_type)
         cpslm_pkg::OP_LOAD_SINGLE:
            if (q.index < SGL_DEPTH) gen_sgl[q.index] = '{q.codepoint, q.sprite_id};
         cpslm_pkg::OP_LOAD_SEQ: if (q.index < SEQ_DEPTH)
            gen_seq[q.index] = '{q.codepoint, q.sprite_id, q.seq_length, q.tail_offset};
         cpslm_pkg::OP_LOAD_TAIL: gen_tail[q.index] = q.codepoint;
         default: ;
      endcase
      req_backlog.push_back(q);
   endtask

   task automatic push_load(input logic [1:0] op, input int idx, input int cp,
                            input logic [LEN_W-1:0] len, input logic [TOFF_W-1:0] toff);
      cpslm_pkg::req_data_type q;
      q = noise_req();
      q.req_type = op;
      q.index = IDX_W'(idx);
      q.codepoint = CP_W'(cp);
      q.seq_length = len;
      q.tail_offset = toff;
      push_req(q);
   endtask

   task automatic push_window(input logic [CP_W-1:0] cps [$]);
      cpslm_pkg::req_data_type q;
      foreach (cps[i]) begin
         q = noise_req();
         q.req_type = cpslm_pkg::OP_QUERY;
         q.codepoint = cps[i];
         q.last = (i == cps.size() - 1);
         push_req(q);
      end
   endtask

   task automatic push_query();
      logic [CP_W-1:0] cps [$];
      int ns, nq, pick, len, k, extra;
      ns = (sgl_limit > SGL_DEPTH) ? SGL_DEPTH : sgl_limit;
      nq = (seq_limit > SEQ_DEPTH) ? SEQ_DEPTH : seq_limit;
      pick = $urandom_range(99);
      if (pick < 55 && nq > 0) begin
         k = $urandom_range(0, nq - 1);
         cps.push_back(gen_seq[k].lead);
         len = gen_seq[k].len;
         if (len == 0 || len > WIN_MAX) len = $urandom_range(1, 4);
         for (int j = 1; j < len; j++)
            cps.push_back(gen_tail[(int'(gen_seq[k].toff) + j - 1) % TAIL_DEPTH]);
         if ($urandom_range(4) == 0 && cps.size() > 1)
            cps[$urandom_range(1, cps.size() - 1)] ^= CP_W'(1);
      end else if (pick < 80 && ns > 0) begin
         cps.push_back(gen_sgl[$urandom_range(0, ns - 1)].cp);
      end else begin
         cps.push_back(($urandom_range(1) == 0) ? CP_W'($urandom()) :
                                                   CP_W'($urandom_range(0, 520)));
      end
      extra = ($urandom_range(9) == 0) ? $urandom_range(2, 6) : $urandom_range(0, 3);
      if ($urandom_range(9) == 0) extra = WIN_MAX + $urandom_range(0, 4) - cps.size();
      for (int j = 0; j < extra; j++) cps.push_back(CP_W'($urandom_range(0, 3)));
      push_window(cps);
   endtask

   task automatic wait_idle();
      while (req_backlog.size() > 0 || start || pending_matches.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == cpslm_pkg::CSR_SGL_LIMIT) sgl_limit = val % (1 << SCNT_W);
      else if (idx == cpslm_pkg::CSR_SEQ_LIMIT) seq_limit = val % (1 << QCNT_W);
   endtask

   initial begin
      logic [CP_W-1:0] cps [$];
      int lens [4];
      int lead, sc, qc;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_csr(cpslm_pkg::CSR_SGL_LIMIT, 0);
      write_csr(cpslm_pkg::CSR_SEQ_LIMIT, 0);
      burst_pct = 20;

      cps = '{CP_W'(5)};
      push_window(cps);
      for (int a = 0; a < 64; a++)
         push_load(cpslm_pkg::OP_LOAD_TAIL, a, $urandom_range(0, 3), '0, '0);
      for (int a = 4080; a < 4096; a++)
         push_load(cpslm_pkg::OP_LOAD_TAIL, a, $urandom_range(0, 3), '0, '0);
      for (int i = 0; i < SGL_FILL; i++)
         push_load(cpslm_pkg::OP_LOAD_SINGLE, i,
            (i == SGL_FILL - 1) ? 21'h1FFFFF : 2 * i, '0, '0);
      for (int g = 0; g < SEQ_FILL / 4; g++) begin
         foreach (lens[j]) lens[j] = pick_len();
         lens.rsort();
         lead = (g == SEQ_FILL / 4 - 1) ? 21'h1FFFFF : 2 * g;
         foreach (lens[j])
            push_load(cpslm_pkg::OP_LOAD_SEQ, 4 * g + j, lead, LEN_W'(lens[j]),
               pick_toff());
      end
      wait_idle();

      write_csr(cpslm_pkg::CSR_SGL_LIMIT, SGL_FILL);
      write_csr(cpslm_pkg::CSR_SEQ_LIMIT, SEQ_FILL);
      write_csr(CSR_SPARE_LO, $urandom_range(0, 4095));
      write_csr(CSR_SPARE_HI, $urandom_range(0, 4095));
      cps = '{21'h1FFFFF};
      push_window(cps);
      cps = '{CP_W'(0)};
      push_window(cps);
      cps = '{CP_W'(1), CP_W'(0)};
      push_window(cps);
      cps = {};
      for (int j = 0; j < WIN_MAX + 2; j++) cps.push_back(CP_W'($urandom_range(0, 3)));
      push_window(cps);
      repeat (3) push_query();
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin sc = SGL_FILL; qc = SEQ_FILL; end
            1: begin sc = SGL_FILL / 2 + 1; qc = SEQ_FILL / 2 + 1; end
            2: begin sc = 1; qc = 1; end
            3: begin sc = 0; qc = SEQ_FILL; end
            4: begin sc = SGL_FILL; qc = 0; end
            default: begin
               sc = $urandom_range(1, SGL_FILL);
               qc = $urandom_range(1, SEQ_FILL);
            end
         endcase
         write_csr(cpslm_pkg::CSR_SGL_LIMIT, sc);
         write_csr(cpslm_pkg::CSR_SEQ_LIMIT, qc);
         burst_pct = (ph == PHASES - 1) ? 0 : (ph % 3 == 1) ? 0 : $urandom_range(10, 50);
         for (int n = 0; n < PHASE_OPS; n++) begin
            case ($urandom_range(7))
               0: begin
                  if ($urandom_range(7) == 0)
                     push_load(cpslm_pkg::OP_LOAD_SINGLE, $urandom_range(SGL_DEPTH, 4095),
                        $urandom(), pick_len(), TOFF_W'($urandom()));
                  else begin
                     lead = $urandom_range(0, SGL_FILL - 1);
                     push_load(cpslm_pkg::OP_LOAD_SINGLE, lead, gen_sgl[lead].cp, '0, '0);
                  end
               end
               1: begin
                  if ($urandom_range(7) == 0)
                     push_load(cpslm_pkg::OP_LOAD_SEQ, $urandom_range(SEQ_DEPTH, 4095),
                        $urandom(), LEN_W'($urandom()), TOFF_W'($urandom()));
                  else begin
                     lead = $urandom_range(0, SEQ_FILL - 1);
                     push_load(cpslm_pkg::OP_LOAD_SEQ, lead, gen_seq[lead].lead, pick_len(),
                        pick_toff());
                  end
               end
               2: push_load(cpslm_pkg::OP_LOAD_TAIL, $urandom_range(0, 4095),
                     ($urandom_range(7) == 0) ? $urandom() : $urandom_range(0, 3), '0, '0);
               default: push_query();
            endcase
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
